// ----- rtl/assert_macros.svh -----
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// assert that a implies b on the same edge
`define ASSERT_IMPL(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");
// assert that a implies b on the next edge
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");
`endif

// ----- rtl/fbc_pkg.sv -----
// package for the frustum box cull block
`timescale 1ns / 1ps
package fbc_pkg;
  localparam int COORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int NUM_PLANES = 6;
  localparam int NUM_CORNERS = 8;
  localparam int NUM_FACES = 6;

  localparam logic [1:0] MODE_PLANE = 2'd0;
  localparam logic [1:0] MODE_CORNER = 2'd1;
  localparam logic [1:0] MODE_TEST = 2'd2;

  localparam logic [1:0] CAUSE_NONE = 2'd0;
  localparam logic [1:0] CAUSE_PLANE = 2'd1;
  localparam logic [1:0] CAUSE_BOUND = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_OUT
  } state_t;
endpackage

// ----- rtl/frustum_box_cull.sv -----
// Frustum box cull top level. Load items (plane or frustum corner) are taken while idle
// and give no result. A test item runs through a row of six plane cells, one per plane,
// all fed the held box bounds, each testing the eight box corners one per cycle through
// its three multipliers; a row of eight corner cells chains the face bound tests.
// A test item passes through a corner select setup step, the eight corners visited
// per plane and a multiplier stage before its result is shown; the result
// register holds one result and the next item is taken once it is transferred.
`timescale 1ns / 1ps
module frustum_box_cull #(
  parameter int COORD_BITS = fbc_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS = fbc_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   mode,
  input  logic [2:0]                   slot,
  input  logic signed [COORD_BITS-1:0] coef_a,
  input  logic signed [COORD_BITS-1:0] coef_b,
  input  logic signed [COORD_BITS-1:0] coef_c,
  input  logic signed [COORD_BITS-1:0] coef_d,
  input  logic signed [COORD_BITS-1:0] box_min_x,
  input  logic signed [COORD_BITS-1:0] box_min_y,
  input  logic signed [COORD_BITS-1:0] box_min_z,
  input  logic signed [COORD_BITS-1:0] box_max_x,
  input  logic signed [COORD_BITS-1:0] box_max_y,
  input  logic signed [COORD_BITS-1:0] box_max_z,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         visible,
  output logic [1:0]                   reject_cause,
  output logic [2:0]                   reject_index
);
  import fbc_pkg::*;
`include "assert_macros.svh"

  state_t state, state_next;
  logic [3:0] cnt, cnt_next;
  logic take;
  logic signed [COORD_BITS-1:0] blo [3], bhi [3];
  logic signed [COORD_BITS-1:0] lv [3];
  logic [NUM_PLANES-1:0] beh;
  logic [NUM_PLANES-1:0] all_beh;
  logic [5:0] flags [NUM_CORNERS+1];
  logic [2:0] corner;

  assign in_stall = (state != ST_IDLE);
  assign take = in_valid && !in_stall;
  assign out_valid = (state == ST_OUT);
  assign lv[0] = coef_a;
  assign lv[1] = coef_b;
  assign lv[2] = coef_c;
  assign flags[0] = 6'h3f;
  assign corner = 3'(cnt - 4'd1);

  always_ff @(posedge clk) begin
    if (take && mode == MODE_TEST) begin
      blo[0] <= box_min_x;
      blo[1] <= box_min_y;
      blo[2] <= box_min_z;
      bhi[0] <= box_max_x;
      bhi[1] <= box_max_y;
      bhi[2] <= box_max_z;
    end
  end

  for (genvar p = 0; p < NUM_PLANES; p++) begin : g_plane
    fbc_plane_cell #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_cell (
      .clk(clk),
      .load(take && mode == MODE_PLANE && slot == 3'(p)),
      .la(coef_a), .lb(coef_b), .lc(coef_c), .ld(coef_d),
      .corner(corner),
      .in_lo(blo), .in_hi(bhi),
      .behind(beh[p])
    );
  end

  for (genvar k = 0; k < NUM_CORNERS; k++) begin : g_corner
    fbc_corner_cell #(.COORD_BITS(COORD_BITS)) u_cell (
      .clk(clk),
      .load(take && mode == MODE_CORNER && slot == 3'(k)),
      .lv(lv), .box_lo(blo), .box_hi(bhi),
      .in_flags(flags[k]), .out_flags(flags[k+1])
    );
  end

  always_comb begin
    state_next = state;
    cnt_next = cnt;
    case (state)
      ST_IDLE: begin
        cnt_next = 4'd0;
        if (take && mode == MODE_TEST) state_next = ST_RUN;
      end
      ST_RUN: begin
        cnt_next = cnt + 4'd1;
        if (cnt == 4'd9) state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!out_stall) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt <= 4'd0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
    end
  end

  // multiplier stage is registered, so it lags corner select; accumulation starts at cnt 2
  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      all_beh <= '1;
    end else if (state == ST_RUN && cnt >= 4'd2) begin
      all_beh <= all_beh & beh;
    end
  end

  always_comb begin
    visible = 1'b1;
    reject_cause = CAUSE_NONE;
    reject_index = 3'd0;
    for (int f = NUM_FACES - 1; f >= 0; f--) begin
      if (flags[NUM_CORNERS][f]) begin
        visible = 1'b0;
        reject_cause = CAUSE_BOUND;
        reject_index = 3'(f);
      end
    end
    for (int p = NUM_PLANES - 1; p >= 0; p--) begin
      if (all_beh[p]) begin
        visible = 1'b0;
        reject_cause = CAUSE_PLANE;
        reject_index = 3'(p);
      end
    end
  end

  `ASSERT_IMPL(a_no_take_busy, clk, rst, state != ST_IDLE, !take)
  `ASSERT_NEXT(a_run_count, clk, rst, state == ST_RUN && cnt != 4'd9, state == ST_RUN)
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(visible))
endmodule

// ----- rtl/fbc_plane_cell.sv -----
// one plane cell: holds a plane and tests the box corners it is handed
`timescale 1ns / 1ps
module fbc_plane_cell #(
  parameter int COORD_BITS = fbc_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS = fbc_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         load,
  input  logic signed [COORD_BITS-1:0] la,
  input  logic signed [COORD_BITS-1:0] lb,
  input  logic signed [COORD_BITS-1:0] lc,
  input  logic signed [COORD_BITS-1:0] ld,
  input  logic        [2:0]            corner,
  input  logic signed [COORD_BITS-1:0] in_lo [3],
  input  logic signed [COORD_BITS-1:0] in_hi [3],
  output logic                         behind
);
  import fbc_pkg::*;
  localparam int PW = 2 * COORD_BITS;
  localparam int SW = PW + 3;

  logic signed [COORD_BITS-1:0] pa, pb, pc, pd;
  logic signed [COORD_BITS-1:0] cx, cy, cz;
  logic signed [PW-1:0] mx, my, mz;
  logic signed [SW-1:0] dterm, sum;

  always_ff @(posedge clk) begin
    if (load) begin
      pa <= la;
      pb <= lb;
      pc <= lc;
      pd <= ld;
    end
  end

  always_comb begin
    cx = corner[0] ? in_hi[0] : in_lo[0];
    cy = corner[1] ? in_hi[1] : in_lo[1];
    cz = corner[2] ? in_hi[2] : in_lo[2];
  end

  always_ff @(posedge clk) begin
    mx <= PW'(pa) * PW'(cx);
    my <= PW'(pb) * PW'(cy);
    mz <= PW'(pc) * PW'(cz);
  end

  always_comb begin
    dterm = SW'(pd) <<< FRAC_BITS;
    sum = dterm + SW'(mx) + SW'(my) + SW'(mz);
    behind = sum[SW-1];
  end
endmodule

// ----- rtl/fbc_corner_cell.sv -----
// one corner cell: holds a frustum corner and compares it against the box bounds
`timescale 1ns / 1ps
module fbc_corner_cell #(
  parameter int COORD_BITS = fbc_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         load,
  input  logic signed [COORD_BITS-1:0] lv [3],
  input  logic signed [COORD_BITS-1:0] box_lo [3],
  input  logic signed [COORD_BITS-1:0] box_hi [3],
  input  logic        [5:0]            in_flags,
  output logic        [5:0]            out_flags
);
  import fbc_pkg::*;
  logic signed [COORD_BITS-1:0] v [3];

  always_ff @(posedge clk) begin
    if (load) v <= lv;
  end

  always_comb begin
    for (int ax = 0; ax < 3; ax++) begin
      out_flags[2*ax]   = in_flags[2*ax]   & (box_hi[ax] < v[ax]);
      out_flags[2*ax+1] = in_flags[2*ax+1] & (v[ax] < box_lo[ax]);
    end
  end
endmodule
